### src/enc_spd_pkg.sv
// Package for the encoder M/T speed estimator.
// Holds sequencer state type, divider structs, register indexes and constants.
package enc_spd_pkg;

    typedef enum logic [3:0] {
        S_IDLE,
        S_PREP,
        S_RATE,
        S_PROD,
        S_CHK,
        S_MAG,
        S_SIGN,
        S_COFF,
        S_COFFW,
        S_FMUL,
        S_FUPD,
        S_Q12,
        S_SC1,
        S_SC2,
        S_OUT
    } t_state;

    typedef struct packed {
        logic       start;
        logic [6:0] nbits;
    } t_div_req;

    typedef struct packed {
        logic busy;
        logic done;
    } t_div_sts;

    localparam logic [2:0] CFG_POLE_PAIRS = 3'd0;
    localparam logic [2:0] CFG_ENC_COUNTS = 3'd1;
    localparam logic [2:0] CFG_BASE_FREQ  = 3'd2;
    localparam logic [2:0] CFG_FILT_TIME  = 3'd3;
    localparam logic [2:0] CFG_RATIO      = 3'd4;

    localparam logic [24:0] FULL_SCALE = 25'h1000000;
    localparam logic [17:0] COFF_NUM   = 18'd163840;
    localparam logic [32:0] SCALE_MUL  = 33'd16777;
    localparam logic [15:0] Q_LIMIT    = 16'd32767;

endpackage

### src/encoder_mt_speed_estimator.sv
// Top level of the encoder M/T speed estimator: sequencer, state and output register.
// Uses enc_spd_pkg and the shared divider enc_spd_div.
//
// Usage: one sample item enters on the s_axis channel (tdata: qep_count,
// timer_now, capture_latch). One result item leaves on m_axis (tdata:
// speed_raw, speed_q12, speed_scaled). Registers are written on the cfg
// channel, which is always ready; write only while idle.
// An item runs the shared serial divider for the timer rate, for the speed
// quotient and for the filter coefficient, besides the sequencer steps.
// An item with no pulses skips the first two divisions.
// s_axis tready is high only while the sequencer is idle.
// The result sits in an output register; the next item is taken while it
// waits. If the receiver still stalls when the next result is done, the
// sequencer holds it until the output register frees.
// Reset (synchronous, active low) loads register defaults, clears history,
// sets the time extension to the low-speed window and clears the filter.
module encoder_mt_speed_estimator import enc_spd_pkg::*; #(
    parameter int CLOCK_MHZ        = 100,
    parameter int LOW_SPEED_WINDOW = 400000
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    input  logic [79:0] i_s_axis_tdata,   // qep_count, timer_now, capture_latch
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    output logic [63:0] o_m_axis_tdata,   // speed_raw, speed_q12, speed_scaled, zero pad
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [2:0]  i_cfg_index,
    input  logic [15:0] i_cfg_data
);

    localparam logic [31:0] RATE_NUM = 32'(64'd25000000 * 64'(CLOCK_MHZ));
    localparam logic [23:0] LSW      = 24'(LOW_SPEED_WINDOW);

    t_state r_state, n_state;

    logic [6:0]  r_pole;
    logic [15:0] r_enc, r_base, r_ratio;
    logic [9:0]  r_ftime;

    logic [31:0] r_last_cnt, r_last_time;
    logic [15:0] r_last_cap;
    logic [23:0] r_ext;
    logic signed [25:0] r_filt;

    logic [31:0] r_in_cnt, r_in_now;
    logic [15:0] r_in_cap;

    logic        r_neg;
    logic [22:0] r_ppa;
    logic [31:0] r_dtime, r_den, r_rate;
    logic [54:0] r_prod;
    logic [24:0] r_mag;
    logic signed [25:0] r_speed;
    logic [14:0] r_coff;
    logic signed [26:0] r_deta;
    logic signed [41:0] r_prodf;
    logic signed [15:0] r_q12;
    logic signed [32:0] r_sc1;
    logic signed [47:0] r_sc2;

    logic        r_mvalid;
    logic [63:0] r_mdata;

    t_div_req    div_req;
    t_div_sts    div_sts;
    logic [63:0] div_num, div_quot;
    logic [31:0] div_den;

    logic        s_acc;
    logic [15:0] d16;
    logic [15:0] apos;
    logic [31:0] dtime_raw, dtime_cor;
    logic signed [26:0] step_sh, step;
    logic signed [16:0] q_sh;
    logic signed [23:0] sc_sh;
    logic signed [15:0] scaled;
    logic        out_free;

    assign s_acc           = i_s_axis_tvalid && o_s_axis_tready;
    assign o_s_axis_tready = (r_state == S_IDLE);
    assign o_cfg_ready     = 1'b1;
    assign out_free        = !r_mvalid || i_m_axis_tready;

    enc_spd_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (div_req),
        .i_num   (div_num),
        .i_den   (div_den),
        .o_sts   (div_sts),
        .o_quot  (div_quot)
    );

    always_comb begin
        d16       = 16'(r_in_cnt - r_last_cnt);
        apos      = d16[15] ? 16'(-d16) : d16;
        dtime_raw = {8'd0, 24'(r_last_time - r_in_now)} + {8'd0, r_ext};
        dtime_cor = dtime_raw + {13'd0, r_last_cap, 3'd0} - {13'd0, r_in_cap, 3'd0};
        step_sh   = 27'(r_prodf >>> 15);
        if (step_sh == 27'sd0 && r_deta != 27'sd0) begin
            step = r_deta[26] ? -27'sd1 : 27'sd1;
        end else begin
            step = step_sh;
        end
        q_sh   = 17'(r_filt >>> 9);
        sc_sh  = 24'(r_sc2 >>> 24);
        if (sc_sh > 24'sd32767) begin
            scaled = 16'sd32767;
        end else if (sc_sh < -24'sd32767) begin
            scaled = -16'sd32767;
        end else begin
            scaled = 16'(sc_sh);
        end
    end

    always_comb begin
        n_state       = r_state;
        div_req.start = 1'b0;
        div_req.nbits = 7'd32;
        div_num       = {r_dtime, 32'd0};
        div_den       = r_dtime;
        case (r_state)
            S_IDLE: begin
                if (s_acc) begin
                    n_state = S_PREP;
                end
            end
            S_PREP: begin
                if (d16 == 16'd0) begin
                    n_state = S_COFF;
                end else if (dtime_raw == 32'd0 && r_ext != 24'd0) begin
                    n_state = S_SIGN;
                end else begin
                    n_state = S_RATE;
                end
            end
            S_RATE: begin
                if (r_dtime == 32'd0 || r_den == 32'd0) begin
                    n_state = S_SIGN;
                end else if (!div_sts.busy && !div_sts.done) begin
                    div_req.start = 1'b1;
                    div_num       = {RATE_NUM, 32'd0};
                    div_den       = r_dtime;
                end else if (div_sts.done) begin
                    n_state = S_PROD;
                end
            end
            S_PROD:  n_state = S_CHK;
            S_CHK: begin
                if (r_prod > 55'h8000000000) begin
                    n_state = S_SIGN;
                end else begin
                    div_req.start = 1'b1;
                    div_req.nbits = 7'd64;
                    div_num       = {r_prod[39:0], 24'd0};
                    div_den       = r_den;
                    n_state       = S_MAG;
                end
            end
            S_MAG: begin
                if (div_sts.done) begin
                    n_state = S_SIGN;
                end
            end
            S_SIGN:  n_state = S_COFF;
            S_COFF: begin
                div_req.start = 1'b1;
                div_req.nbits = 7'd18;
                div_num       = {COFF_NUM, 46'd0};
                div_den       = 32'(12'd10 + 12'(r_ftime) * 12'd3);
                n_state       = S_COFFW;
            end
            S_COFFW: begin
                if (div_sts.done) begin
                    n_state = S_FMUL;
                end
            end
            S_FMUL:  n_state = S_FUPD;
            S_FUPD:  n_state = S_Q12;
            S_Q12:   n_state = S_SC1;
            S_SC1:   n_state = S_SC2;
            S_SC2:   n_state = S_OUT;
            S_OUT: begin
                if (out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pole  <= 7'd2;
            r_enc   <= 16'd1024;
            r_base  <= 16'd500;
            r_ftime <= 10'd0;
            r_ratio <= 16'd1000;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                CFG_POLE_PAIRS: r_pole  <= i_cfg_data[6:0];
                CFG_ENC_COUNTS: r_enc   <= i_cfg_data;
                CFG_BASE_FREQ:  r_base  <= i_cfg_data;
                CFG_FILT_TIME:  r_ftime <= i_cfg_data[9:0];
                CFG_RATIO:      r_ratio <= i_cfg_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_last_cnt  <= '0;
            r_last_time <= '0;
            r_last_cap  <= '0;
            r_ext       <= LSW;
            r_filt      <= '0;
            r_mvalid    <= 1'b0;
        end else begin
            if (r_state == S_OUT && out_free) begin
                r_mvalid <= 1'b1;
            end else if (r_mvalid && i_m_axis_tready) begin
                r_mvalid <= 1'b0;
            end
            case (r_state)
                S_PREP: begin
                    if (d16 != 16'd0) begin
                        r_ext       <= '0;
                        r_last_cnt  <= r_in_cnt;
                        r_last_time <= r_in_now;
                        r_last_cap  <= r_in_cap;
                    end else if (dtime_raw >= 32'(LSW)) begin
                        r_ext       <= LSW;
                        r_last_cnt  <= r_in_cnt;
                        r_last_time <= r_in_now;
                        r_last_cap  <= '0;
                    end
                end
                S_FUPD: r_filt <= 26'(r_filt + step);
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_acc) begin
            r_in_cnt <= i_s_axis_tdata[31:0];
            r_in_now <= i_s_axis_tdata[63:32];
            r_in_cap <= i_s_axis_tdata[79:64];
        end
        case (r_state)
            S_PREP: begin
                r_neg   <= d16[15];
                r_ppa   <= 23'(r_pole) * 23'(apos);
                r_den   <= 32'(r_enc) * 32'(r_base);
                r_dtime <= (r_ext == 24'd0) ? dtime_cor : dtime_raw;
                r_mag   <= FULL_SCALE;
                if (d16 == 16'd0) begin
                    r_speed <= (dtime_raw >= 32'(LSW)) ? 26'sd0 : r_filt;
                end
            end
            S_RATE: begin
                if (div_sts.done) begin
                    r_rate <= div_quot[31:0];
                end
            end
            S_PROD:  r_prod <= 55'(r_ppa) * 55'(r_rate);
            S_MAG: begin
                if (div_sts.done) begin
                    r_mag <= (div_quot > 64'(FULL_SCALE)) ? FULL_SCALE : div_quot[24:0];
                end
            end
            S_SIGN:  r_speed <= r_neg ? -$signed({1'b0, r_mag}) : $signed({1'b0, r_mag});
            S_COFFW: begin
                if (div_sts.done) begin
                    r_coff <= div_quot[14:0];
                end
            end
            S_FMUL: begin
                r_deta  <= 27'(r_speed) - 27'(r_filt);
                r_prodf <= 42'(27'(r_speed) - 27'(r_filt)) * 42'($signed({1'b0, r_coff}));
            end
            S_Q12: begin
                if (q_sh > 17'sd32767) begin
                    r_q12 <= 16'sd32767;
                end else if (q_sh < -17'sd32767) begin
                    r_q12 <= -16'sd32767;
                end else begin
                    r_q12 <= 16'(q_sh);
                end
            end
            S_SC1:   r_sc1 <= 33'(r_q12) * $signed({17'd0, r_ratio});
            S_SC2:   r_sc2 <= 48'(r_sc1) * 48'($signed(SCALE_MUL));
            S_OUT: begin
                if (out_free) begin
                    r_mdata <= {6'd0, scaled, r_q12, r_speed};
                end
            end
            default: ;
        endcase
    end

    assign o_m_axis_tvalid = r_mvalid;
    assign o_m_axis_tdata  = r_mdata;

    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_acc |=> !o_s_axis_tready)
        else $error("input taken while sequencer busy");

    a_filt_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_filt <= 26'sd16777216) && (r_filt >= -26'sd16777216))
        else $error("filter state out of range");

    a_div_done_waited: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        div_sts.done |-> (r_state == S_RATE || r_state == S_MAG || r_state == S_COFFW))
        else $error("divider finished outside a wait state");

    a_out_from_seq: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_mvalid) |-> $past(r_state) == S_OUT)
        else $error("result raised outside output step");

endmodule

### src/enc_spd_div.sv
// Shared restoring divider, one quotient bit per cycle.
// Numerator is left-aligned; nbits steps give the quotient in the low bits. Uses enc_spd_pkg.
module enc_spd_div import enc_spd_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  t_div_req    i_req,
    input  logic [63:0] i_num,
    input  logic [31:0] i_den,
    output t_div_sts    o_sts,
    output logic [63:0] o_quot
);

    logic [6:0]  r_cnt;
    logic        r_busy, r_done;
    logic [31:0] r_rem, r_den;
    logic [63:0] r_num, r_quo;
    logic [32:0] trial;
    logic        qbit;

    always_comb begin
        trial = {r_rem, r_num[63]};
        qbit  = (trial >= {1'b0, r_den});
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_cnt  <= i_req.nbits;
            end else if (r_busy) begin
                r_cnt <= r_cnt - 7'd1;
                if (r_cnt == 7'd1) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_num <= i_num;
            r_den <= i_den;
            r_rem <= '0;
            r_quo <= '0;
        end else if (r_busy) begin
            r_num <= {r_num[62:0], 1'b0};
            r_quo <= {r_quo[62:0], qbit};
            r_rem <= qbit ? 32'(trial - {1'b0, r_den}) : trial[31:0];
        end
    end

    assign o_sts.busy = r_busy;
    assign o_sts.done = r_done;
    assign o_quot     = r_quo;

endmodule
